// ----- hdl/nnr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the nearest-neighbor rotation unit.
// No dependencies.

package nnr_pkg;

    localparam int COORD_W = 8;
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;
    localparam int DIM_W   = 9;
    localparam int COEF_W  = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int DELTA_W = 11;
    localparam int PROD_W  = DELTA_W + COEF_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 9'd256;
    localparam logic [COEF_W-1:0] RST_COS_COEF     = 16'h4000;
    localparam logic [COEF_W-1:0] RST_SIN_COEF     = 16'h0000;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_COS_COEF     = 2'd2,
        REG_SIN_COEF     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIXEL_W-1:0] pix;
    } item_t;

    typedef struct packed {
        logic             in_frame;
        logic [DIM_W-1:0] sx;
        logic [DIM_W-1:0] sy;
    } src_coord_t;

endpackage

// ----- hdl/nnr_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.

module nnr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/nnr_map.sv -----
`timescale 1ns / 1ps
// Reverse coordinate mapper: three register stages (products, sums, rounding).
// Depends on nnr_pkg.

module nnr_map (
    input  logic                             clk,
    input  logic                             en,
    input  logic [nnr_pkg::COORD_W-1:0]      col,
    input  logic [nnr_pkg::COORD_W-1:0]      row,
    input  logic [nnr_pkg::DIM_W-1:0]        w,
    input  logic [nnr_pkg::DIM_W-1:0]        h,
    input  logic signed [nnr_pkg::COEF_W-1:0] c,
    input  logic signed [nnr_pkg::COEF_W-1:0] s,
    output nnr_pkg::src_coord_t              res
);

    localparam int COEF_FRAC_BITS = nnr_pkg::COEF_FRAC_BITS;
    localparam int PROD_W = nnr_pkg::PROD_W;
    localparam int BASE_W = nnr_pkg::DIM_W + COEF_FRAC_BITS + 1;
    localparam int SUM_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 2;
    localparam int Q_W    = SUM_W - COEF_FRAC_BITS - 1;
    localparam int DW     = nnr_pkg::DIM_W;

    logic signed [nnr_pkg::DELTA_W-1:0] dx;
    logic signed [nnr_pkg::DELTA_W-1:0] dy;
    logic signed [PROD_W-1:0] p_xc_reg, p_ys_reg, p_yc_reg, p_xs_reg;
    logic signed [PROD_W-1:0] p_xc_next, p_ys_next, p_yc_next, p_xs_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic signed [SUM_W-1:0]  sum_x_next, sum_y_next;
    logic [SUM_W-1:0]         w_term, h_term;
    logic [SUM_W-1:0]         mag_x, mag_y, rnd_x, rnd_y;
    logic [Q_W-1:0]           q_x, q_y;
    logic                     in_x, in_y;
    nnr_pkg::src_coord_t      res_reg, res_next;

    assign dx = $signed({2'b00, col, 1'b0}) - $signed({2'b00, w});
    assign dy = $signed({2'b00, row, 1'b0}) - $signed({2'b00, h});

    assign p_xc_next = dx * c;
    assign p_ys_next = dy * s;
    assign p_yc_next = dy * c;
    assign p_xs_next = dx * s;

    assign w_term = {{(SUM_W-DW-COEF_FRAC_BITS){1'b0}}, w, {COEF_FRAC_BITS{1'b0}}};
    assign h_term = {{(SUM_W-DW-COEF_FRAC_BITS){1'b0}}, h, {COEF_FRAC_BITS{1'b0}}};

    assign sum_x_next = {{(SUM_W-PROD_W){p_xc_reg[PROD_W-1]}}, p_xc_reg}
                      + {{(SUM_W-PROD_W){p_ys_reg[PROD_W-1]}}, p_ys_reg}
                      + $signed(w_term);
    assign sum_y_next = {{(SUM_W-PROD_W){p_yc_reg[PROD_W-1]}}, p_yc_reg}
                      - {{(SUM_W-PROD_W){p_xs_reg[PROD_W-1]}}, p_xs_reg}
                      + $signed(h_term);

    // round half away from zero on the magnitude
    assign mag_x = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign mag_y = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign rnd_x = mag_x + (SUM_W'(1) << COEF_FRAC_BITS);
    assign rnd_y = mag_y + (SUM_W'(1) << COEF_FRAC_BITS);
    assign q_x   = rnd_x[SUM_W-1:COEF_FRAC_BITS+1];
    assign q_y   = rnd_y[SUM_W-1:COEF_FRAC_BITS+1];

    // a negative source is inside only when it rounds to zero
    assign in_x = sum_x_reg[SUM_W-1] ? (q_x == '0) : (q_x < {{(Q_W-DW){1'b0}}, w});
    assign in_y = sum_y_reg[SUM_W-1] ? (q_y == '0) : (q_y < {{(Q_W-DW){1'b0}}, h});

    always_comb
    begin
        res_next.in_frame = in_x && in_y;
        res_next.sx       = sum_x_reg[SUM_W-1] ? '0 : q_x[DW-1:0];
        res_next.sy       = sum_y_reg[SUM_W-1] ? '0 : q_y[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_xc_reg  <= p_xc_next;
            p_ys_reg  <= p_ys_next;
            p_yc_reg  <= p_yc_next;
            p_xs_reg  <= p_xs_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- hdl/nearest_neighbor_image_rotation_unit.sv -----
`timescale 1ns / 1ps
// Nearest-neighbor frame rotation unit, top level.
// Depends on nnr_pkg, nnr_map, nnr_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: a store
//   (operation 0) writes blue/green/red at (col,row) into the frame memory; a
//   fetch (operation 1) names an output coordinate and returns the rotated
//   source pixel, or black with inside_res low when the source is off-frame.
//   Every item, store or fetch, yields exactly one output item
//   (out_valid/out_ready); a store returns zeros.
//   Configuration (cfg_wr_en/cfg_addr/cfg_wdata) sets frame size and the
//   Q2.14 cosine/sine; write it only while no item is in flight.
//   Throughput: one item per cycle unless the output item is stalled; five
//   register stages (input, multiply, sum, round, memory read with output)
//   let a new item enter every cycle while not stalled, and all memory reads
//   and writes happen in one stage, in item order.
//   A stalled receiver freezes the whole pipeline and drops in_ready; the
//   output item holds until taken.
//   Reset clears the pipeline and loads 256x256, cos=1.0, sin=0; the frame
//   memory content is undefined until stored.

module nearest_neighbor_image_rotation_unit #(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [nnr_pkg::COORD_W-1:0]    col,
    input  logic [nnr_pkg::COORD_W-1:0]    row,
    input  logic [nnr_pkg::CHAN_W-1:0]     blue_in,
    input  logic [nnr_pkg::CHAN_W-1:0]     green_in,
    input  logic [nnr_pkg::CHAN_W-1:0]     red_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nnr_pkg::CHAN_W-1:0]     blue_out,
    output logic [nnr_pkg::CHAN_W-1:0]     green_out,
    output logic [nnr_pkg::CHAN_W-1:0]     red_out,
    output logic                           inside_res,
    input  logic                           cfg_wr_en,
    input  logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [nnr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DW     = nnr_pkg::DIM_W;
    localparam logic [DW-1:0] W_CAP = (MAX_WIDTH > 511) ? 9'd511 : DW'(MAX_WIDTH);
    localparam logic [DW-1:0] H_CAP = (MAX_HEIGHT > 511) ? 9'd511 : DW'(MAX_HEIGHT);

    logic [DW-1:0]                 frame_width_reg, frame_height_reg;
    logic [nnr_pkg::COEF_W-1:0]    cos_coef_reg, sin_coef_reg;
    logic [DW-1:0]                 w_eff, h_eff;

    logic                          adv;
    logic [3:0]                    valid_reg, valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          inside_reg, inside_next;
    nnr_pkg::item_t                item_reg [4];
    nnr_pkg::item_t                item_in;
    nnr_pkg::src_coord_t           src;

    logic                          store_ok, ram_we, ram_re;
    logic [ADDR_W-1:0]             store_addr, fetch_addr;
    logic [nnr_pkg::PIXEL_W-1:0]   ram_q;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= nnr_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= nnr_pkg::RST_FRAME_HEIGHT;
            cos_coef_reg     <= nnr_pkg::RST_COS_COEF;
            sin_coef_reg     <= nnr_pkg::RST_SIN_COEF;
        end
        else if (cfg_wr_en)
        begin
            unique case (nnr_pkg::cfg_reg_t'(cfg_addr))
                nnr_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[DW-1:0];
                nnr_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[DW-1:0];
                nnr_pkg::REG_COS_COEF:     cos_coef_reg     <= cfg_wdata;
                nnr_pkg::REG_SIN_COEF:     sin_coef_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // frame size clamped to 1..MAX
    assign w_eff = (frame_width_reg == '0) ? DW'(1) :
                   ((frame_width_reg > W_CAP) ? W_CAP : frame_width_reg);
    assign h_eff = (frame_height_reg == '0) ? DW'(1) :
                   ((frame_height_reg > H_CAP) ? H_CAP : frame_height_reg);

    // pipeline control: everything moves unless the output item is stalled
    assign adv      = !(out_valid_reg && !out_ready);
    assign in_ready = adv;

    assign valid_next     = {valid_reg[2:0], in_valid};
    assign out_valid_next = valid_reg[3];
    assign inside_next    = valid_reg[3] && (item_reg[3].op == nnr_pkg::OP_FETCH)
                            && src.in_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            inside_reg    <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            inside_reg    <= inside_next;
        end
    end

    always_comb
    begin
        item_in.op  = operation;
        item_in.col = col;
        item_in.row = row;
        item_in.pix = {red_in, green_in, blue_in};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[0] <= item_in;
            item_reg[1] <= item_reg[0];
            item_reg[2] <= item_reg[1];
            item_reg[3] <= item_reg[2];
        end
    end

    nnr_map u_map (
        .clk (clk),
        .en  (adv),
        .col (item_reg[0].col),
        .row (item_reg[0].row),
        .w   (w_eff),
        .h   (h_eff),
        .c   ($signed(cos_coef_reg)),
        .s   ($signed(sin_coef_reg)),
        .res (src)
    );

    // memory stage: stores and fetches hit the RAM in item order
    assign store_ok   = (int'(item_reg[3].col) < MAX_WIDTH)
                        && (int'(item_reg[3].row) < MAX_HEIGHT);
    assign store_addr = ADDR_W'(item_reg[3].row) * ADDR_W'(MAX_WIDTH)
                        + ADDR_W'(item_reg[3].col);
    assign fetch_addr = ADDR_W'(src.sy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(src.sx);
    assign ram_we     = adv && valid_reg[3] && (item_reg[3].op == nnr_pkg::OP_STORE)
                        && store_ok;
    assign ram_re     = adv && valid_reg[3] && (item_reg[3].op == nnr_pkg::OP_FETCH);

    nnr_ram #(
        .WIDTH (nnr_pkg::PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (store_addr),
        .wdata (item_reg[3].pix),
        .re    (ram_re),
        .raddr (fetch_addr),
        .rdata (ram_q)
    );

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign blue_out   = inside_reg ? ram_q[nnr_pkg::CHAN_W-1:0] : '0;
    assign green_out  = inside_reg ? ram_q[2*nnr_pkg::CHAN_W-1:nnr_pkg::CHAN_W] : '0;
    assign red_out    = inside_reg ? ram_q[3*nnr_pkg::CHAN_W-1:2*nnr_pkg::CHAN_W] : '0;

endmodule

// ----- hdl/nnr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the rotation unit, with its bind statement.
// Depends on nnr_pkg and nearest_neighbor_image_rotation_unit.

module nnr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [nnr_pkg::CHAN_W-1:0]  blue_out,
    input logic [nnr_pkg::CHAN_W-1:0]  green_out,
    input logic [nnr_pkg::CHAN_W-1:0]  red_out,
    input logic                        inside_res
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inside_res)
            && $stable(blue_out) && $stable(green_out) && $stable(red_out))
        else $error("output item changed while stalled");

    // off-frame or store items are black
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> blue_out == '0 && green_out == '0 && red_out == '0)
        else $error("nonzero pixel without inside_res");

    // input is only held back by a stalled output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("in_ready low without output stall");

endmodule

bind nearest_neighbor_image_rotation_unit nnr_checker u_nnr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .blue_out   (blue_out),
    .green_out  (green_out),
    .red_out    (red_out),
    .inside_res (inside_res)
);

// ----- tb/tb_nearest_neighbor_image_rotation_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of nearest_neighbor_image_rotation_unit: a directed table, then
// random store/fetch traffic over several frame sizes and angles, checked by an inline model.
// Depends on nnr_pkg and the unit RTL.

module tb_nearest_neighbor_image_rotation_unit;

    localparam int  WATCHDOG_LIMIT  = 2000;
    localparam int  DRAIN_CYCLES    = 20;
    localparam int  N_DIRECTED      = 15;
    localparam int  N_PHASES        = 10;
    localparam int  ITEMS_PER_PHASE = 64;
    localparam int  FRAC            = nnr_pkg::COEF_FRAC_BITS;
    localparam int  MEM_W           = 256;
    localparam int  MEM_H           = 256;
    localparam int  CW              = nnr_pkg::CHAN_W;
    localparam int  XW              = nnr_pkg::COORD_W;
    localparam int  PW              = nnr_pkg::PIXEL_W;
    localparam int  DWD             = nnr_pkg::CFG_DATA_W;
    localparam real PI              = 3.14159265358979323846;

    typedef struct packed {
        logic          ins;
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
    } pixel_res_t;

    typedef struct {
        logic          op;
        logic [XW-1:0] c;
        logic [XW-1:0] r;
        logic [PW-1:0] pix;
        bit            typed;
        logic [PW-1:0] epix;
        logic          eins;
    } dir_row_t;

    typedef struct {
        logic [DWD-1:0] w;
        logic [DWD-1:0] h;
        logic [DWD-1:0] cs;
        logic [DWD-1:0] sn;
        bit             gaps;
    } frame_cfg_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic                           operation;
    logic [XW-1:0]                  col;
    logic [XW-1:0]                  row;
    logic [CW-1:0]                  blue_in;
    logic [CW-1:0]                  green_in;
    logic [CW-1:0]                  red_in;
    logic                           out_valid;
    logic                           out_ready;
    logic [CW-1:0]                  blue_out;
    logic [CW-1:0]                  green_out;
    logic [CW-1:0]                  red_out;
    logic                           inside_res;
    logic                           cfg_wr_en;
    logic [nnr_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [DWD-1:0]                 cfg_wdata;

    // typed expectation travelling with the item on the input channel
    bit                    cur_typed;
    logic [PW-1:0]         cur_epix;
    logic                  cur_eins;

    // model state
    logic [PW-1:0]         frame_mem [0:MEM_W*MEM_H-1];
    bit                    frame_written [0:MEM_W*MEM_H-1];
    logic [nnr_pkg::DIM_W-1:0]         width_reg;
    logic [nnr_pkg::DIM_W-1:0]         height_reg;
    logic signed [nnr_pkg::COEF_W-1:0] cos_reg;
    logic signed [nnr_pkg::COEF_W-1:0] sin_reg;
    pixel_res_t            expected_px [$];

    dir_row_t              dir_tab [N_DIRECTED];
    frame_cfg_t            cfgs [N_PHASES];
    bit                    gaps_on;
    int                    burst_left;
    int                    rx_cyc;
    int                    rx_hold;
    int                    idle_cycles;
    int                    n_errors;
    int                    n_results;
    int                    n_stores;
    int                    n_fetches;
    int                    n_inside;

    nearest_neighbor_image_rotation_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .col        (col),
        .row        (row),
        .blue_in    (blue_in),
        .green_in   (green_in),
        .red_in     (red_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .blue_out   (blue_out),
        .green_out  (green_out),
        .red_out    (red_out),
        .inside_res (inside_res),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int dim_of(input logic [nnr_pkg::DIM_W-1:0] v, input int maxv);
        int d;
        d = int'(v);
        if (d < 1)
        begin
            d = 1;
        end
        if (d > maxv)
        begin
            d = maxv;
        end
        return d;
    endfunction

    // divide by 2^(FRAC+1), half away from zero
    function automatic longint round_half(input longint s);
        longint m;
        longint q;
        m = (s < 0) ? -s : s;
        q = (m + (64'sd1 <<< FRAC)) >>> (FRAC + 1);
        return (s < 0) ? -q : q;
    endfunction

    function automatic bit src_of(input logic [XW-1:0] c, input logic [XW-1:0] r,
                                  output int sx, output int sy);
        longint w;
        longint h;
        longint cs;
        longint sn;
        longint dx;
        longint dy;
        w  = dim_of(width_reg, MEM_W);
        h  = dim_of(height_reg, MEM_H);
        cs = longint'(cos_reg);
        sn = longint'(sin_reg);
        dx = 2 * longint'(c) - w;
        dy = 2 * longint'(r) - h;
        sx = int'(round_half(dx * cs + dy * sn + (w <<< FRAC)));
        sy = int'(round_half(dy * cs - dx * sn + (h <<< FRAC)));
        return (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
    endfunction

    function automatic logic [DWD-1:0] q14(input real v);
        int k;
        if (v >= 0.0)
        begin
            k = $rtoi(v * 16384.0 + 0.5);
        end
        else
        begin
            k = -$rtoi(-v * 16384.0 + 0.5);
        end
        return k[DWD-1:0];
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: mismatch on %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // scoreboard and watchdog
    always @(posedge clk)
    begin : scoreboard
        pixel_res_t    want;
        pixel_res_t    got;
        logic [PW-1:0] px;
        int            sx;
        int            sy;
        if (in_valid && in_ready)
        begin
            want = '0;
            if (operation == nnr_pkg::OP_STORE)
            begin
                frame_mem[{row, col}]     = {red_in, green_in, blue_in};
                frame_written[{row, col}] = 1'b1;
                n_stores++;
            end
            else
            begin
                n_fetches++;
                if (src_of(col, row, sx, sy))
                begin
                    px   = frame_mem[sy * MEM_W + sx];
                    want = {1'b1, px};
                    n_inside++;
                end
            end
            if (cur_typed)
            begin
                want = {cur_eins, cur_epix};
            end
            expected_px.push_back(want);
        end
        if (out_valid && out_ready)
        begin
            n_results++;
            if (expected_px.size() == 0)
            begin
                n_errors++;
                $display("%0t: result with nothing expected: %h %h %h %b", $time,
                         red_out, green_out, blue_out, inside_res);
            end
            else
            begin
                want = expected_px.pop_front();
                got  = {inside_res, red_out, green_out, blue_out};
                check_field("blue_out", want.b, got.b);
                check_field("green_out", want.g, got.g);
                check_field("red_out", want.r, got.r);
                check_field("inside_res", {7'd0, want.ins}, {7'd0, got.ins});
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_px.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: stall pattern steps through always ready, random, random-length holds and a periodic pattern
    always @(negedge clk)
    begin : rx_stall
        logic rdy;
        rx_cyc++;
        case ((rx_cyc >> 8) % 4)
            0:
            begin
                rdy = 1'b1;
            end
            1:
            begin
                rdy = 1'($urandom_range(0, 1));
            end
            2:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    rdy = 1'b0;
                end
                else
                begin
                    rdy = 1'b1;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        rx_hold = $urandom_range(1, 12);
                    end
                end
            end
            default:
            begin
                rdy = (rx_cyc % 3) != 0;
            end
        endcase
        out_ready <= rdy;
    end

    task automatic pace();
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    task automatic send_item(input logic op, input logic [XW-1:0] c,
                             input logic [XW-1:0] r, input logic [PW-1:0] pix,
                             input bit typed, input logic [PW-1:0] epix, input logic eins);
        pace();
        in_valid  <= 1'b1;
        operation <= op;
        col       <= c;
        row       <= r;
        blue_in   <= pix[7:0];
        green_in  <= pix[15:8];
        red_in    <= pix[23:16];
        cur_typed <= typed;
        cur_epix  <= epix;
        cur_eins  <= eins;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_px.size() != 0)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic set_reg(input nnr_pkg::cfg_reg_t idx, input logic [DWD-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        case (idx)
            nnr_pkg::REG_FRAME_WIDTH:  width_reg  = v[nnr_pkg::DIM_W-1:0];
            nnr_pkg::REG_FRAME_HEIGHT: height_reg = v[nnr_pkg::DIM_W-1:0];
            nnr_pkg::REG_COS_COEF:     cos_reg    = v;
            default:                   sin_reg    = v;
        endcase
        @(negedge clk);
    endtask

    task automatic random_item();
        int            w;
        int            h;
        int            sx;
        int            sy;
        logic [XW-1:0] c;
        logic [XW-1:0] r;
        w = dim_of(width_reg, MEM_W);
        h = dim_of(height_reg, MEM_H);
        if ($urandom_range(0, 99) < 35)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                c = 8'($urandom);
                r = 8'($urandom);
            end
            else
            begin
                c = 8'($urandom_range(0, w - 1));
                r = 8'($urandom_range(0, h - 1));
            end
            send_item(nnr_pkg::OP_STORE, c, r, 24'($urandom), 1'b0, '0, 1'b0);
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                c = 8'($urandom);
                r = 8'($urandom);
            end
            else
            begin
                c = 8'($urandom_range(0, (w + 2 > 255) ? 255 : w + 2));
                r = 8'($urandom_range(0, (h + 2 > 255) ? 255 : h + 2));
            end
            // never read a location that was not stored: fill the source first
            if (src_of(c, r, sx, sy) && !frame_written[sy * MEM_W + sx])
            begin
                send_item(nnr_pkg::OP_STORE, sx[7:0], sy[7:0], 24'($urandom),
                          1'b0, '0, 1'b0);
            end
            send_item(nnr_pkg::OP_FETCH, c, r, 24'($urandom), 1'b0, '0, 1'b0);
        end
    endtask

    initial
    begin : stimulus
        real ang;
        int  ph;
        int  k;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = nnr_pkg::OP_STORE;
        col        = '0;
        row        = '0;
        blue_in    = '0;
        green_in   = '0;
        red_in     = '0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = nnr_pkg::REG_FRAME_WIDTH;
        cfg_wdata  = '0;
        cur_typed  = 1'b0;
        cur_epix   = '0;
        cur_eins   = 1'b0;
        width_reg  = nnr_pkg::RST_FRAME_WIDTH;
        height_reg = nnr_pkg::RST_FRAME_HEIGHT;
        cos_reg    = nnr_pkg::RST_COS_COEF;
        sin_reg    = nnr_pkg::RST_SIN_COEF;
        gaps_on    = 1'b1;
        burst_left = 0;

        // reset settings: 256x256, identity, so a fetch returns the pixel at its own spot
        dir_tab[0]  = '{nnr_pkg::OP_STORE, 8'd0,   8'd0,   24'hFFFFFF, 1'b1, 24'h000000, 1'b0};
        dir_tab[1]  = '{nnr_pkg::OP_STORE, 8'd255, 8'd255, 24'h000000, 1'b1, 24'h000000, 1'b0};
        dir_tab[2]  = '{nnr_pkg::OP_STORE, 8'd255, 8'd0,   24'h0000FF, 1'b1, 24'h000000, 1'b0};
        dir_tab[3]  = '{nnr_pkg::OP_STORE, 8'd0,   8'd255, 24'hFF0000, 1'b1, 24'h000000, 1'b0};
        dir_tab[4]  = '{nnr_pkg::OP_STORE, 8'd128, 8'd128, 24'hA5C3E1, 1'b1, 24'h000000, 1'b0};
        dir_tab[5]  = '{nnr_pkg::OP_STORE, 8'd1,   8'd2,   24'h5A3C1E, 1'b1, 24'h000000, 1'b0};
        dir_tab[6]  = '{nnr_pkg::OP_FETCH, 8'd0,   8'd0,   24'h000000, 1'b1, 24'hFFFFFF, 1'b1};
        dir_tab[7]  = '{nnr_pkg::OP_FETCH, 8'd255, 8'd255, 24'hFFFFFF, 1'b1, 24'h000000, 1'b1};
        dir_tab[8]  = '{nnr_pkg::OP_FETCH, 8'd255, 8'd0,   24'h000000, 1'b1, 24'h0000FF, 1'b1};
        dir_tab[9]  = '{nnr_pkg::OP_FETCH, 8'd0,   8'd255, 24'h000000, 1'b1, 24'hFF0000, 1'b1};
        dir_tab[10] = '{nnr_pkg::OP_FETCH, 8'd128, 8'd128, 24'h000000, 1'b1, 24'hA5C3E1, 1'b1};
        dir_tab[11] = '{nnr_pkg::OP_FETCH, 8'd1,   8'd2,   24'hFFFFFF, 1'b1, 24'h5A3C1E, 1'b1};
        dir_tab[12] = '{nnr_pkg::OP_STORE, 8'd1,   8'd2,   24'h123456, 1'b1, 24'h000000, 1'b0};
        dir_tab[13] = '{nnr_pkg::OP_FETCH, 8'd1,   8'd2,   24'h000000, 1'b1, 24'h123456, 1'b1};
        dir_tab[14] = '{nnr_pkg::OP_FETCH, 8'd128, 8'd128, 24'h000000, 1'b0, 24'h000000, 1'b0};

        cfgs[0] = '{16'd256, 16'd256, q14($cos(30.0 * PI / 180.0)),
                    q14($sin(30.0 * PI / 180.0)), 1'b1};
        cfgs[1] = '{16'd1, 16'd1, 16'h4000, 16'h0000, 1'b1};
        // zero and oversized frame, coefficients beyond +-1.0
        cfgs[2] = '{16'd0, 16'd511, 16'h7FFF, 16'h8000, 1'b0};
        cfgs[3] = '{16'd256, 16'd256, 16'h0000, 16'h4000, 1'b1};
        cfgs[4] = '{16'd256, 16'd256, 16'hC000, 16'h0000, 1'b0};
        for (ph = 5; ph < N_PHASES - 1; ph++)
        begin
            ang = real'($urandom_range(0, 359)) * PI / 180.0;
            cfgs[ph] = '{16'($urandom_range(1, (ph == 5) ? 256 : 64)),
                         16'($urandom_range(1, 64)), q14($cos(ang)), q14($sin(ang)),
                         ph[0]};
        end
        cfgs[N_PHASES-1] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             1'b1};

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < N_DIRECTED; k++)
        begin
            send_item(dir_tab[k].op, dir_tab[k].c, dir_tab[k].r, dir_tab[k].pix,
                      dir_tab[k].typed, dir_tab[k].epix, dir_tab[k].eins);
        end

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            set_reg(nnr_pkg::REG_FRAME_WIDTH, cfgs[ph].w);
            set_reg(nnr_pkg::REG_FRAME_HEIGHT, cfgs[ph].h);
            set_reg(nnr_pkg::REG_COS_COEF, cfgs[ph].cs);
            set_reg(nnr_pkg::REG_SIN_COEF, cfgs[ph].sn);
            cfg_wr_en <= 1'b0;
            @(negedge clk);
            gaps_on    = cfgs[ph].gaps;
            burst_left = 0;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                random_item();
                if (k == ITEMS_PER_PHASE / 2 || $urandom_range(0, 149) == 0)
                begin
                    drain();
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d stores and %0d fetches (%0d sourced inside the frame)",
                 n_stores, n_fetches, n_inside);
        $display("over %0d settings; %0d results compared, %0d mismatches",
                 N_PHASES + 1, n_results, n_errors);
        if (n_errors == 0 && expected_px.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
